/* rtl/psid_pkg.sv */
`timescale 1ns / 1ps

package psid_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_W    = 16;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int EPS_W      = 24;
   localparam logic [EPS_W-1:0] EPS_RESET = 24'd66;

   // serial multiplier: 80 by 80 bits, one multiplier bit a cycle
   localparam int SM_W    = 80;
   localparam int SM_CNTW = 7;

   localparam logic [1:0] DIM_POINT  = 2'd0;
   localparam logic [1:0] DIM_LINE   = 2'd1;
   localparam logic [1:0] DIM_PLANE  = 2'd2;
   localparam logic [1:0] DIM_VOLUME = 2'd3;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PICK,
      ST_FETCH,
      ST_PREP,
      ST_LINE,
      ST_LTEST,
      ST_NSET,
      ST_PLANE,
      ST_PTEST,
      ST_OUT
   } state_type;

endpackage

/* rtl/point_set_intrinsic_dimension_3d.sv */
`timescale 1ns / 1ps
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_coord_x/y/z, req_last_point
// rsp      out        rsp_valid/rsp_stall   rsp_dimension, indices, side, box
// csr      in         csr_valid/csr_ready   csr_epsilon_q8_16
// points load one a beat per cycle into a 1024-entry store; one shared 36x36
// multiplier and one bit-serial 80x80 multiplier do all later arithmetic.
// after the last point of n: pick, fetch, prep, a line pass over all n points,
// line test, normal setup, a plane pass over all n points and plane test, with
// later steps skipped once the dimension is settled; req_stall is high meanwhile.
// reset is synchronous; it clears state, point count and box but not the store.
// a result waits in its output register while the next set loads.

module point_set_intrinsic_dimension_3d
   import psid_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic                      req_last_point,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_dimension,
   output logic [IDX_W-1:0]          rsp_origin_index,
   output logic [IDX_W-1:0]          rsp_far_index,
   output logic [IDX_W-1:0]          rsp_off_line_index,
   output logic [IDX_W-1:0]          rsp_off_plane_index,
   output logic                      rsp_positive_side,
   output logic signed [COORD_W-1:0] rsp_box_min_x,
   output logic signed [COORD_W-1:0] rsp_box_min_y,
   output logic signed [COORD_W-1:0] rsp_box_min_z,
   output logic signed [COORD_W-1:0] rsp_box_max_x,
   output logic signed [COORD_W-1:0] rsp_box_max_y,
   output logic signed [COORD_W-1:0] rsp_box_max_z,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [EPS_W-1:0]          csr_epsilon_q8_16
);

   state_type state_ff, state_in;
   logic [3:0]       step_ff, step_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [EPS_W-1:0] eps_ff;

   logic signed [COORD_W-1:0] min_ff [3], min_in [3];
   logic signed [COORD_W-1:0] max_ff [3], max_in [3];
   logic [IDX_W-1:0] min_idx_ff [3], min_idx_in [3];
   logic [IDX_W-1:0] max_idx_ff [3], max_idx_in [3];

   logic [3*COORD_W-1:0] mem [MAX_POINTS];
   logic [3*COORD_W-1:0] rd_data_ff;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic signed [COORD_W-1:0] req_pt [3];
   logic signed [COORD_W-1:0] rd_pt [3];

   logic [IDX_W-1:0] e0_ff, e0_in, e1_ff, e1_in, e2_ff, e2_in, e3_ff, e3_in;
   logic [COORD_W-1:0] range_ff, range_in;
   logic signed [COORD_W-1:0] o_ff [3], o_in [3];
   logic signed [16:0] d_ff [3], d_in [3];
   logic signed [16:0] v_ff [3], v_in [3];
   logic signed [34:0] c_ff [3], c_in [3];
   logic signed [34:0] n_ff [3], n_in [3];
   logic signed [71:0] acc_ff, acc_in;
   logic signed [71:0] prod_ff;
   logic signed [35:0] mul_a, mul_b;
   logic signed [71:0] mag;
   logic [68:0]  best_ff, best_in;
   logic [35:0]  dd_ff, dd_in;
   logic [68:0]  nn_ff, nn_in;
   logic [SM_W-1:0] thr_ff, thr_in;
   logic [127:0] bb_ff, bb_in;
   logic         pos_ff, pos_in;
   logic [1:0]   dim_ff, dim_in;

   logic            sm_start;
   logic [SM_W-1:0] sm_opa, sm_opb;
   logic [2*SM_W-1:0] sm_a_ff, sm_p_ff;
   logic [SM_W-1:0]   sm_b_ff;
   logic [SM_CNTW-1:0] sm_cnt_ff;
   logic              sm_busy_ff;

   logic              out_load;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_dim_ff;
   logic [IDX_W-1:0]  rsp_e0_ff, rsp_e1_ff, rsp_e2_ff, rsp_e3_ff;
   logic              rsp_pos_ff;
   logic signed [COORD_W-1:0] rsp_min_ff [3], rsp_max_ff [3];

   logic [COORD_W-1:0] rng [3];
   logic [COORD_W-1:0] rbest;
   logic [IDX_W-1:0]   r0, r1;
   logic               last_idx;

   assign req_pt[0] = req_coord_x;
   assign req_pt[1] = req_coord_y;
   assign req_pt[2] = req_coord_z;
   assign rd_pt[0]  = signed'(rd_data_ff[15:0]);
   assign rd_pt[1]  = signed'(rd_data_ff[31:16]);
   assign rd_pt[2]  = signed'(rd_data_ff[47:32]);
   assign req_stall = (state_ff != ST_LOAD);
   assign csr_ready = 1'b1;
   assign last_idx  = ((idx_ff + 1'b1) == cnt_ff);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rng[k] = 16'(17'(max_ff[k]) - 17'(min_ff[k]));
      end
      rbest = rng[0];
      r0    = min_idx_ff[0];
      r1    = max_idx_ff[0];
      for (int k = 1; k < 3; k++) begin
         if (rng[k] > rbest) begin
            rbest = rng[k];
            r0    = min_idx_ff[k];
            r1    = max_idx_ff[k];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      min_idx_in = min_idx_ff;
      max_idx_in = max_idx_ff;
      e0_in      = e0_ff;
      e1_in      = e1_ff;
      e2_in      = e2_ff;
      e3_in      = e3_ff;
      range_in   = range_ff;
      o_in       = o_ff;
      d_in       = d_ff;
      v_in       = v_ff;
      c_in       = c_ff;
      n_in       = n_ff;
      acc_in     = acc_ff;
      best_in    = best_ff;
      dd_in      = dd_ff;
      nn_in      = nn_ff;
      thr_in     = thr_ff;
      bb_in      = bb_ff;
      pos_in     = pos_ff;
      dim_in     = dim_ff;
      mul_a      = '0;
      mul_b      = '0;
      rd_en      = 1'b0;
      rd_addr    = idx_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      sm_start   = 1'b0;
      sm_opa     = thr_ff;
      sm_opb     = SM_W'(dd_ff);
      out_load   = 1'b0;
      mag        = acc_ff[71] ? -acc_ff : acc_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (cnt_ff < CNT_W'(MAX_POINTS)) begin
                  wr_en = 1'b1;
                  for (int k = 0; k < 3; k++) begin
                     if (cnt_ff == '0) begin
                        min_in[k]     = req_pt[k];
                        max_in[k]     = req_pt[k];
                        min_idx_in[k] = '0;
                        max_idx_in[k] = '0;
                     end else if (req_pt[k] < min_ff[k]) begin
                        min_in[k]     = req_pt[k];
                        min_idx_in[k] = cnt_ff[IDX_W-1:0];
                     end else if (req_pt[k] > max_ff[k]) begin
                        max_in[k]     = req_pt[k];
                        max_idx_in[k] = cnt_ff[IDX_W-1:0];
                     end
                  end
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_last_point) begin
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            range_in = rbest;
            e0_in    = r0;
            e1_in    = r1;
            e2_in    = r0;
            e3_in    = r0;
            pos_in   = 1'b0;
            step_in  = '0;
            if ({rbest, 16'd0} < {8'd0, eps_ff}) begin
               dim_in   = DIM_POINT;
               e1_in    = r0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               4'd0: begin
                  rd_en   = 1'b1;
                  rd_addr = e0_ff;
               end
               4'd1: begin
                  o_in    = rd_pt;
                  rd_en   = 1'b1;
                  rd_addr = e1_ff;
               end
               default: begin
                  for (int k = 0; k < 3; k++) begin
                     d_in[k] = 17'(rd_pt[k]) - 17'(o_ff[k]);
                  end
                  step_in  = '0;
                  state_in = ST_PREP;
               end
            endcase
         end
         ST_PREP: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               4'd0: begin
                  mul_a = 36'(d_ff[0]);
                  mul_b = 36'(d_ff[0]);
               end
               4'd1: begin
                  acc_in = prod_ff;
                  mul_a  = 36'(d_ff[1]);
                  mul_b  = 36'(d_ff[1]);
               end
               4'd2: begin
                  acc_in = acc_ff + prod_ff;
                  mul_a  = 36'(d_ff[2]);
                  mul_b  = 36'(d_ff[2]);
               end
               4'd3: begin
                  acc_in = acc_ff + prod_ff;
                  mul_a  = signed'(36'(eps_ff));
                  mul_b  = signed'(36'(eps_ff));
               end
               4'd4: begin
                  dd_in  = acc_ff[35:0];
                  thr_in = SM_W'(prod_ff);
                  mul_a  = signed'(36'(range_ff));
                  mul_b  = signed'(36'(range_ff));
               end
               4'd5: begin
                  sm_start = 1'b1;
                  sm_opa   = thr_ff;
                  sm_opb   = SM_W'(prod_ff);
               end
               default: begin
                  step_in = step_ff;
                  if (!sm_busy_ff) begin
                     thr_in   = sm_p_ff[SM_W-1:0];
                     best_in  = '0;
                     idx_in   = '0;
                     step_in  = '0;
                     state_in = ST_LINE;
                  end
               end
            endcase
         end
         ST_LINE, ST_NSET: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               4'd0: begin
                  rd_en   = 1'b1;
                  rd_addr = (state_ff == ST_NSET) ? e2_ff : idx_ff[IDX_W-1:0];
               end
               4'd1: begin
                  for (int k = 0; k < 3; k++) begin
                     v_in[k] = 17'(rd_pt[k]) - 17'(o_ff[k]);
                  end
               end
               4'd2: begin
                  mul_a = 36'(d_ff[1]);
                  mul_b = 36'(v_ff[2]);
               end
               4'd3: begin
                  c_in[0] = prod_ff[34:0];
                  mul_a   = 36'(d_ff[2]);
                  mul_b   = 36'(v_ff[1]);
               end
               4'd4: begin
                  c_in[0] = c_ff[0] - prod_ff[34:0];
                  mul_a   = 36'(d_ff[2]);
                  mul_b   = 36'(v_ff[0]);
               end
               4'd5: begin
                  c_in[1] = prod_ff[34:0];
                  mul_a   = 36'(d_ff[0]);
                  mul_b   = 36'(v_ff[2]);
               end
               4'd6: begin
                  c_in[1] = c_ff[1] - prod_ff[34:0];
                  mul_a   = 36'(d_ff[0]);
                  mul_b   = 36'(v_ff[1]);
               end
               4'd7: begin
                  c_in[2] = prod_ff[34:0];
                  mul_a   = 36'(d_ff[1]);
                  mul_b   = 36'(v_ff[0]);
               end
               4'd8: begin
                  c_in[2] = c_ff[2] - prod_ff[34:0];
                  mul_a   = 36'(c_ff[0]);
                  mul_b   = 36'(c_ff[0]);
               end
               4'd9: begin
                  acc_in = prod_ff;
                  mul_a  = 36'(c_ff[1]);
                  mul_b  = 36'(c_ff[1]);
               end
               4'd10: begin
                  acc_in = acc_ff + prod_ff;
                  mul_a  = 36'(c_ff[2]);
                  mul_b  = 36'(c_ff[2]);
               end
               4'd11: begin
                  acc_in = acc_ff + prod_ff;
               end
               default: begin
                  step_in = '0;
                  if (state_ff == ST_NSET) begin
                     n_in     = c_ff;
                     nn_in    = acc_ff[68:0];
                     best_in  = '0;
                     idx_in   = '0;
                     state_in = ST_PLANE;
                  end else begin
                     // squared distance from the line, scaled by |d|^2
                     if (best_ff < acc_ff[68:0]) begin
                        best_in = acc_ff[68:0];
                        e2_in   = idx_ff[IDX_W-1:0];
                     end
                     idx_in = idx_ff + 1'b1;
                     if (last_idx) begin
                        state_in = ST_LTEST;
                     end
                  end
               end
            endcase
         end
         ST_LTEST: begin
            if (step_ff == '0) begin
               sm_start = 1'b1;
               sm_opa   = thr_ff;
               sm_opb   = SM_W'(dd_ff);
               step_in  = 4'd1;
            end else if (!sm_busy_ff) begin
               step_in = '0;
               if ({59'd0, best_ff, 32'd0} < sm_p_ff) begin
                  dim_in   = DIM_LINE;
                  e2_in    = e1_ff;
                  e3_in    = e1_ff;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_NSET;
               end
            end
         end
         ST_PLANE: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               4'd0: begin
                  rd_en = 1'b1;
               end
               4'd1: begin
                  for (int k = 0; k < 3; k++) begin
                     v_in[k] = 17'(rd_pt[k]) - 17'(o_ff[k]);
                  end
               end
               4'd2: begin
                  mul_a = 36'(n_ff[0]);
                  mul_b = 36'(v_ff[0]);
               end
               4'd3: begin
                  acc_in = prod_ff;
                  mul_a  = 36'(n_ff[1]);
                  mul_b  = 36'(v_ff[1]);
               end
               4'd4: begin
                  acc_in = acc_ff + prod_ff;
                  mul_a  = 36'(n_ff[2]);
                  mul_b  = 36'(v_ff[2]);
               end
               4'd5: begin
                  acc_in = acc_ff + prod_ff;
               end
               default: begin
                  step_in = '0;
                  if (best_ff < mag[68:0]) begin
                     best_in = mag[68:0];
                     pos_in  = !acc_ff[71];
                     e3_in   = idx_ff[IDX_W-1:0];
                  end
                  idx_in = idx_ff + 1'b1;
                  if (last_idx) begin
                     state_in = ST_PTEST;
                  end
               end
            endcase
         end
         ST_PTEST: begin
            unique case (step_ff)
               4'd0: begin
                  sm_start = 1'b1;
                  sm_opa   = SM_W'(best_ff);
                  sm_opb   = SM_W'(best_ff);
                  step_in  = 4'd1;
               end
               4'd1: begin
                  if (!sm_busy_ff) begin
                     bb_in   = sm_p_ff[127:0];
                     step_in = 4'd2;
                  end
               end
               4'd2: begin
                  sm_start = 1'b1;
                  sm_opa   = thr_ff;
                  sm_opb   = SM_W'(nn_ff);
                  step_in  = 4'd3;
               end
               default: begin
                  if (!sm_busy_ff) begin
                     step_in  = '0;
                     state_in = ST_OUT;
                     if ({bb_ff, 32'd0} < sm_p_ff) begin
                        dim_in = DIM_PLANE;
                        e3_in  = e2_ff;
                        pos_in = 1'b0;
                     end else begin
                        dim_in = DIM_VOLUME;
                     end
                  end
               end
            endcase
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               cnt_in   = '0;
               idx_in   = '0;
               for (int k = 0; k < 3; k++) begin
                  min_in[k]     = '0;
                  max_in[k]     = '0;
                  min_idx_in[k] = '0;
                  max_idx_in[k] = '0;
               end
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         step_ff  <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         eps_ff   <= EPS_RESET;
         for (int k = 0; k < 3; k++) begin
            min_ff[k]     <= '0;
            max_ff[k]     <= '0;
            min_idx_ff[k] <= '0;
            max_idx_ff[k] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         cnt_ff     <= cnt_in;
         idx_ff     <= idx_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         min_idx_ff <= min_idx_in;
         max_idx_ff <= max_idx_in;
         if (csr_valid && csr_ready) begin
            eps_ff <= csr_epsilon_q8_16;
         end
      end
   end

   always_ff @(posedge clock) begin
      e0_ff    <= e0_in;
      e1_ff    <= e1_in;
      e2_ff    <= e2_in;
      e3_ff    <= e3_in;
      range_ff <= range_in;
      o_ff     <= o_in;
      d_ff     <= d_in;
      v_ff     <= v_in;
      c_ff     <= c_in;
      n_ff     <= n_in;
      acc_ff   <= acc_in;
      prod_ff  <= mul_a * mul_b;
      best_ff  <= best_in;
      dd_ff    <= dd_in;
      nn_ff    <= nn_in;
      thr_ff   <= thr_in;
      bb_ff    <= bb_in;
      pos_ff   <= pos_in;
      dim_ff   <= dim_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[IDX_W-1:0]] <= {req_coord_z, req_coord_y, req_coord_x};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // shift-add multiplier, one bit of the second operand a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         sm_busy_ff <= 1'b0;
         sm_cnt_ff  <= '0;
      end else if (sm_start) begin
         sm_a_ff    <= (2*SM_W)'(sm_opa);
         sm_b_ff    <= sm_opb;
         sm_p_ff    <= '0;
         sm_cnt_ff  <= '0;
         sm_busy_ff <= 1'b1;
      end else if (sm_busy_ff) begin
         if (sm_b_ff[0]) begin
            sm_p_ff <= sm_p_ff + sm_a_ff;
         end
         sm_a_ff   <= sm_a_ff << 1;
         sm_b_ff   <= sm_b_ff >> 1;
         sm_cnt_ff <= sm_cnt_ff + 1'b1;
         if (sm_cnt_ff == SM_CNTW'(SM_W - 1)) begin
            sm_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_dim_ff <= dim_ff;
         rsp_e0_ff  <= e0_ff;
         rsp_e1_ff  <= e1_ff;
         rsp_e2_ff  <= e2_ff;
         rsp_e3_ff  <= e3_ff;
         rsp_pos_ff <= pos_ff;
         rsp_min_ff <= min_ff;
         rsp_max_ff <= max_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_dimension       = rsp_dim_ff;
   assign rsp_origin_index    = rsp_e0_ff;
   assign rsp_far_index       = rsp_e1_ff;
   assign rsp_off_line_index  = rsp_e2_ff;
   assign rsp_off_plane_index = rsp_e3_ff;
   assign rsp_positive_side   = rsp_pos_ff;
   assign rsp_box_min_x       = rsp_min_ff[0];
   assign rsp_box_min_y       = rsp_min_ff[1];
   assign rsp_box_min_z       = rsp_min_ff[2];
   assign rsp_box_max_x       = rsp_max_ff[0];
   assign rsp_box_max_y       = rsp_max_ff[1];
   assign rsp_box_max_z       = rsp_max_ff[2];

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");

   a_point_far: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dimension == DIM_POINT |-> rsp_far_index == rsp_origin_index)
      else $error("point result with distinct far index");

   a_side_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dimension != DIM_VOLUME |->
         !rsp_positive_side && rsp_off_plane_index == rsp_off_line_index)
      else $error("side flag or plane index wrong below full volume");
`endif

endmodule
